### design/deq_pkg.sv
// Shared types and codes for the double-ended queue and its storage cells.
package deq_pkg;

  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // How a lane's occupied length changes: the valid marks move one cell.
  typedef enum logic [1:0] {
    MODE_HOLD   = 2'd0,
    MODE_GROW   = 2'd1,
    MODE_SHRINK = 2'd2
  } mode_t;

  typedef struct packed {
    logic  en;
    func_t func;
    mode_t upper_mode;
    mode_t lower_mode;
    word_t value;
  } deq_ctrl_t;

endpackage

### design/deq_cell.sv
// One storage cell of the folded queue: an upper-lane word, a lower-lane word and their valid marks.
module deq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  deq_pkg::deq_ctrl_t ctrl,
  input  deq_pkg::word_t    left_upper,
  input  deq_pkg::word_t    left_lower,
  input  logic              left_upper_vld,
  input  logic              left_lower_vld,
  input  deq_pkg::word_t    right_upper,
  input  deq_pkg::word_t    right_lower,
  input  logic              right_upper_vld,
  input  logic              right_lower_vld,
  output deq_pkg::word_t    upper_r,
  output deq_pkg::word_t    lower_r,
  output logic              upper_vld_r,
  output logic              lower_vld_r
);
  import deq_pkg::*;

  word_t upper_nxt;
  word_t lower_nxt;
  logic  upper_vld_nxt;
  logic  lower_vld_nxt;

  function automatic logic move_mark(mode_t mode, logic own, logic left, logic right);
    logic res;
    case (mode)
      MODE_GROW:   res = left;
      MODE_SHRINK: res = right;
      default:     res = own;
    endcase
    return res;
  endfunction

  always_comb begin
    upper_nxt = upper_r;
    lower_nxt = lower_r;
    unique case (ctrl.func)
      FUNC_PUSH_FRONT: begin
        // Upper lane slides away from the front; the fold point may take our own upper word.
        upper_nxt = left_upper;
        lower_nxt = lower_vld_r ? lower_r : upper_r;
      end
      FUNC_PUSH_BACK: begin
        // Lower lane slides away from the back; the fold point may pull a word up.
        upper_nxt = upper_vld_r ? upper_r : left_lower;
        lower_nxt = left_lower;
      end
      FUNC_POP_FRONT: begin
        upper_nxt = right_upper_vld ? right_upper : lower_r;
      end
      FUNC_POP_BACK: begin
        lower_nxt = right_lower_vld ? right_lower : right_upper;
      end
    endcase
    upper_vld_nxt = move_mark(ctrl.upper_mode, upper_vld_r, left_upper_vld, right_upper_vld);
    lower_vld_nxt = move_mark(ctrl.lower_mode, lower_vld_r, left_lower_vld, right_lower_vld);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_vld_r <= 1'b0;
      lower_vld_r <= 1'b0;
    end else if (ctrl.en) begin
      upper_vld_r <= upper_vld_nxt;
      lower_vld_r <= lower_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      upper_r <= upper_nxt;
      lower_r <= lower_nxt;
    end
  end

endmodule

### design/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit words.
//
// The queue takes one item in every clock cycle: an item is accepted at a rising edge where
// start is high and busy is low, and busy is never raised. Each item pushes a word at the
// front or back, or pops one from either end. Its result appears on the out_ ports for exactly
// one cycle, flagged by out_valid, in the cycle right after acceptance; the receiver must take
// it then, since results cannot be held off. The storage cells all update together at the
// accepting edge of an item that succeeds. The result carries the popped word (zero for pushes
// and rejected pops), a status (ok, pop on empty, push on full), the new occupancy and the
// words now at the front and back (zero when the queue is empty). A rejected item leaves the
// queue unchanged. Storage words need no reset; only the valid marks, the count and the result
// strobe are cleared, so the block is ready as soon as reset is released.
//
// Storage is a row of ceil(DEPTH/2) cells folded in half. Writing the n held words as
// e0 (front) .. e(n-1) (back), the upper lane of cell j holds e(j) and the lower lane holds
// e(n-1-j). The upper lane is kept at ceil(n/2) words and the lower at floor(n/2), so the fold
// point, where the two lanes meet, always sits inside one cell or between two neighbors. Every
// operation is then a one-step slide of one lane plus a local hand-over at the fold, and the
// front and back words are always in cell zero.
module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  deq_pkg::func_t               in_func,
  input  deq_pkg::word_t               in_push_value,
  output logic                         out_valid,
  output deq_pkg::word_t               out_popped_value,
  output deq_pkg::status_t             out_status,
  output logic [$clog2(DEPTH+1)-1:0]   out_occupancy,
  output deq_pkg::word_t               out_front_word,
  output deq_pkg::word_t               out_back_word
);
  import deq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int NCELL = (DEPTH + 1) / 2;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  // Occupancy and the registered parts of the result.
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  word_t            popped_r, popped_nxt;
  status_t          status_r, status_nxt;

  logic      accept;
  logic      is_push;
  logic      odd_count;
  deq_ctrl_t ctrl;

  // Cell outputs, one entry per cell.
  word_t upper_q [NCELL];
  word_t lower_q [NCELL];
  logic  upper_vld [NCELL];
  logic  lower_vld [NCELL];

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign is_push = (in_func == FUNC_PUSH_FRONT) || (in_func == FUNC_PUSH_BACK);
  assign odd_count = count_r[0];

  // Decide the status, the popped word and how each lane's length moves. A push grows the
  // upper lane when the count is even and the lower lane when it is odd; a pop shrinks the
  // upper lane when the count is odd and the lower lane when it is even.
  always_comb begin
    status_nxt      = STATUS_OK;
    popped_nxt      = '0;
    count_nxt       = count_r;
    ctrl.func       = in_func;
    ctrl.value      = in_push_value;
    ctrl.upper_mode = MODE_HOLD;
    ctrl.lower_mode = MODE_HOLD;
    if (is_push) begin
      if (count_r == FULL_COUNT) begin
        status_nxt = STATUS_FULL;
      end else begin
        count_nxt = count_r + 1'b1;
        if (odd_count) begin
          ctrl.lower_mode = MODE_GROW;
        end else begin
          ctrl.upper_mode = MODE_GROW;
        end
      end
    end else begin
      if (count_r == '0) begin
        status_nxt = STATUS_EMPTY;
      end else begin
        count_nxt = count_r - 1'b1;
        if (odd_count) begin
          ctrl.upper_mode = MODE_SHRINK;
        end else begin
          ctrl.lower_mode = MODE_SHRINK;
        end
        // The front word is always the first upper slot; the back word is the first lower
        // slot unless only one word is held.
        if (in_func == FUNC_POP_FRONT) begin
          popped_nxt = upper_q[0];
        end else begin
          popped_nxt = lower_vld[0] ? lower_q[0] : upper_q[0];
        end
      end
    end
    ctrl.en = accept && (status_nxt == STATUS_OK);
  end

  // The row of cells. Cell zero sees the pushed word on its left side, with both left marks
  // set; the last cell sees empty neighbors on its right.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    word_t left_upper, left_lower, right_upper, right_lower;
    logic  left_upper_vld, left_lower_vld, right_upper_vld, right_lower_vld;

    if (i == 0) begin : g_first
      assign left_upper     = ctrl.value;
      assign left_lower     = ctrl.value;
      assign left_upper_vld = 1'b1;
      assign left_lower_vld = 1'b1;
    end else begin : g_mid_left
      assign left_upper     = upper_q[i-1];
      assign left_lower     = lower_q[i-1];
      assign left_upper_vld = upper_vld[i-1];
      assign left_lower_vld = lower_vld[i-1];
    end

    if (i == NCELL - 1) begin : g_last
      assign right_upper     = '0;
      assign right_lower     = '0;
      assign right_upper_vld = 1'b0;
      assign right_lower_vld = 1'b0;
    end else begin : g_mid_right
      assign right_upper     = upper_q[i+1];
      assign right_lower     = lower_q[i+1];
      assign right_upper_vld = upper_vld[i+1];
      assign right_lower_vld = lower_vld[i+1];
    end

    deq_cell u_cell (
      .clk             (clk),
      .rst_n           (rst_n),
      .ctrl            (ctrl),
      .left_upper      (left_upper),
      .left_lower      (left_lower),
      .left_upper_vld  (left_upper_vld),
      .left_lower_vld  (left_lower_vld),
      .right_upper     (right_upper),
      .right_lower     (right_lower),
      .right_upper_vld (right_upper_vld),
      .right_lower_vld (right_lower_vld),
      .upper_r         (upper_q[i]),
      .lower_r         (lower_q[i]),
      .upper_vld_r     (upper_vld[i]),
      .lower_vld_r     (lower_vld[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r <= popped_nxt;
      status_r <= status_nxt;
    end
  end

  // The ends of the queue are read straight from cell zero, which has already taken the update.
  assign out_valid        = out_valid_r;
  assign out_popped_value = popped_r;
  assign out_status       = status_r;
  assign out_occupancy    = count_r;
  assign out_front_word   = upper_vld[0] ? upper_q[0] : '0;
  assign out_back_word    = lower_vld[0] ? lower_q[0] : (upper_vld[0] ? upper_q[0] : '0);

  // Every accepted item gives exactly one result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("result strobe missing after an accepted item");

  // The occupancy can never pass the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("occupancy above capacity");

  // The first upper slot holds a word exactly when the queue is not empty.
  a_front_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) == upper_vld[0])
    else $error("front valid mark out of step with occupancy");

  // A successful push raises the occupancy by one.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_push && (count_r != FULL_COUNT)) |=> (count_r == $past(count_r) + 1'b1))
    else $error("push did not raise the occupancy by one");

endmodule
